### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/qmf_pkg.sv
package qmf_pkg;

   // Default sizing of the problem.
   localparam int MAX_VARS_DEFAULT   = 64;
   localparam int COEFF_BITS_DEFAULT = 16;

   // Field widths of the channels.
   localparam int MODE_BITS     = 2;
   localparam int ROW_BITS      = 6;
   localparam int COL_BITS      = 6;
   localparam int COEFF_IN_BITS = 16;
   localparam int THR_BITS      = 22;
   localparam int DELTA_BITS    = 23;
   localparam int ENERGY_BITS   = 28;
   localparam int ACTIVE_BITS   = 7;

   // Working width of the accumulator; holds any sum over 127 variables.
   localparam int ACC_BITS = 32;

   // Request tdata layout, lowest bit first.
   localparam int REQ_ROW_LSB   = 0;
   localparam int REQ_COL_LSB   = REQ_ROW_LSB + ROW_BITS;
   localparam int REQ_COEFF_LSB = REQ_COL_LSB + COL_BITS;
   localparam int REQ_BIT_LSB   = REQ_COEFF_LSB + COEFF_IN_BITS;
   localparam int REQ_THR_LSB   = REQ_BIT_LSB + 1;
   localparam int REQ_USED_BITS = REQ_THR_LSB + THR_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int RSP_ACC_LSB    = 0;
   localparam int RSP_DELTA_LSB  = RSP_ACC_LSB + 1;
   localparam int RSP_ENERGY_LSB = RSP_DELTA_LSB + DELTA_BITS;
   localparam int RSP_BIT_LSB    = RSP_ENERGY_LSB + ENERGY_BITS;
   localparam int RSP_USED_BITS  = RSP_BIT_LSB + 1;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(64);

   // Item kinds.
   localparam logic [MODE_BITS-1:0] MODE_LOAD_COEFF = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOAD_BIT   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_EVAL       = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_FLIP       = 2'd3;

   localparam int DELTA_MAX  = (1 << (DELTA_BITS - 1)) - 1;
   localparam int DELTA_MIN  = -DELTA_MAX - 1;
   localparam int ENERGY_MAX = (1 << (ENERGY_BITS - 1)) - 1;
   localparam int ENERGY_MIN = -ENERGY_MAX - 1;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic step;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [MODE_BITS-1:0] in_mode;
      logic                 in_flip_ok;
      logic                 scan_last;
      logic                 out_free;
   } status_type;

   function automatic logic [DELTA_BITS-1:0] sat_delta(input logic signed [ACC_BITS-1:0] v);
      logic [DELTA_BITS-1:0] r;
      if (v > $signed(ACC_BITS'(DELTA_MAX))) r = DELTA_BITS'(DELTA_MAX);
      else if (v < $signed(ACC_BITS'(DELTA_MIN))) r = DELTA_BITS'(DELTA_MIN);
      else r = v[DELTA_BITS-1:0];
      return r;
   endfunction

   function automatic logic [ENERGY_BITS-1:0] sat_energy(input logic signed [ACC_BITS-1:0] v);
      logic [ENERGY_BITS-1:0] r;
      if (v > $signed(ACC_BITS'(ENERGY_MAX))) r = ENERGY_BITS'(ENERGY_MAX);
      else if (v < $signed(ACC_BITS'(ENERGY_MIN))) r = ENERGY_BITS'(ENERGY_MIN);
      else r = v[ENERGY_BITS-1:0];
      return r;
   endfunction

endpackage

### hw/rtl/qubo_metropolis_flip_engine.sv
// Metropolis flip engine for a binary quadratic problem.
// The request channel carries one item per transaction: tuser selects load
// coefficient, load bit, evaluate energy or flip attempt. Loads take effect in
// the accept cycle and respond through the finish state. A flip attempt on an
// active variable reads one coupling coefficient per cycle from the single
// read port of the coefficient memory, one per active variable; an evaluation
// walks the upper triangle. One item is in work at a time; the next request is
// taken as soon as the previous result sits in the output register. Every item
// yields exactly one response transaction with the accept flag, the energy
// change, the running energy and the addressed bit. When the receiver stalls,
// the response holds in its output register and a following item waits in its
// final cycle until that register frees. Reset clears all solution bits and
// the running energy and sets the active size to 64; the coefficient memory is
// not cleared and must be loaded before use. The csr port writes the active
// size; the user must use it only while idle; the block itself does not
// enforce this.
module qubo_metropolis_flip_engine #(
   parameter int MAX_VARS   = qmf_pkg::MAX_VARS_DEFAULT,
   parameter int COEFF_BITS = qmf_pkg::COEFF_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [qmf_pkg::ACTIVE_BITS-1:0]   csr_wr_data,  // active_size
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index, col_index, coeff_value, bit_value, accept_threshold, zero fill
   input  logic [qmf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic [qmf_pkg::MODE_BITS-1:0]     req_tuser,    // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted, flip_delta, energy_total, bit_after, zero fill
   output logic [qmf_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   import qmf_pkg::*;

   cmd_type    cmd;
   status_type status;

   qmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   qmf_datapath #(
      .MAX_VARS   (MAX_VARS),
      .COEFF_BITS (COEFF_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### hw/rtl/qmf_ram.sv
module qmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/qmf_ctrl.sv
`include "assert_macros.svh"

module qmf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output qmf_pkg::cmd_type    cmd,
   input  qmf_pkg::status_type status
);

   import qmf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_FLIP   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cmd.capture = accept;
   assign cmd.step    = (state_ff == ST_EVAL) || (state_ff == ST_FLIP);
   assign cmd.finish  = (state_ff == ST_FINISH) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (status.in_mode) inside
                  MODE_LOAD_COEFF, MODE_LOAD_BIT: state_in = ST_FINISH;
                  MODE_EVAL: state_in = ST_EVAL;
                  MODE_FLIP: state_in = status.in_flip_ok ? ST_FLIP : ST_FINISH;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_EVAL, ST_FLIP: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         // The last coefficient read lands in the accumulator during this cycle.
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `ASSERT_NEXT(a_drain_to_finish, clock, reset, state_ff == ST_DRAIN, state_ff == ST_FINISH)

endmodule

### hw/rtl/qmf_datapath.sv
`include "assert_macros.svh"

module qmf_datapath #(
   parameter int MAX_VARS   = qmf_pkg::MAX_VARS_DEFAULT,
   parameter int COEFF_BITS = qmf_pkg::COEFF_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [qmf_pkg::ACTIVE_BITS-1:0]   csr_wr_data,
   input  logic [qmf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic [qmf_pkg::MODE_BITS-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qmf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  qmf_pkg::cmd_type                  cmd,
   output qmf_pkg::status_type               status
);

   import qmf_pkg::*;

   localparam int VAR_BITS  = $clog2(MAX_VARS);
   localparam int CMP_BITS  = (VAR_BITS + 1 > ACTIVE_BITS) ? VAR_BITS + 1 : ACTIVE_BITS;
   localparam int CW        = (COEFF_BITS < COEFF_IN_BITS) ? COEFF_BITS : COEFF_IN_BITS;
   localparam int ADDR_BITS = 2 * VAR_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   // Incoming fields.
   logic [ROW_BITS-1:0]      in_row;
   logic [COL_BITS-1:0]      in_col;
   logic [COEFF_IN_BITS-1:0] in_coeff;
   logic                     in_bit;
   logic [THR_BITS-1:0]      in_thr;
   logic [CMP_BITS-1:0]      in_row_ext;
   logic [CMP_BITS-1:0]      in_col_ext;
   logic [VAR_BITS-1:0]      in_row_var;
   logic [VAR_BITS-1:0]      in_col_var;
   logic                     in_row_valid;

   // Configuration and derived active range.
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [CMP_BITS-1:0]    active_ext;
   logic [CMP_BITS-1:0]    max_ext;
   logic [CMP_BITS-1:0]    nm1_full;
   logic [VAR_BITS-1:0]    nm1_w;
   logic [CMP_BITS-1:0]    nm1_ext;

   // Captured item.
   logic [MODE_BITS-1:0] mode_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic [THR_BITS-1:0]  thr_ff;
   logic [CMP_BITS-1:0]  row_ext;
   logic [VAR_BITS-1:0]  row_var;
   logic                 row_valid;

   // Problem state.
   logic [MAX_VARS-1:0]    bits_ff;
   logic [MAX_VARS-1:0]    bits_in;
   logic [ENERGY_BITS-1:0] energy_ff;
   logic [ENERGY_BITS-1:0] energy_in;

   // Scan.
   logic [VAR_BITS-1:0]  i_ff;
   logic [VAR_BITS-1:0]  i_in;
   logic [VAR_BITS-1:0]  j_ff;
   logic [VAR_BITS-1:0]  j_in;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 include_now;
   logic                 rd_valid_ff;
   logic                 inc_ff;
   logic [CW-1:0]        rd_data;
   logic                 coeff_we;
   logic signed [ACC_BITS-1:0] acc_ff;
   logic signed [ACC_BITS-1:0] coeff_ext;

   // Result.
   logic                       x_k;
   logic signed [ACC_BITS-1:0] delta_full;
   logic signed [ACC_BITS-1:0] thr_ext;
   logic signed [ACC_BITS-1:0] energy_ext;
   logic signed [ACC_BITS-1:0] energy_sum;
   logic                       flip_ok;
   logic                       flip_accept;
   logic                       rsp_valid_ff;
   logic                       out_acc_ff;
   logic [DELTA_BITS-1:0]      out_delta_ff;
   logic [ENERGY_BITS-1:0]     out_energy_ff;
   logic                       out_bit_ff;

   assign in_row   = req_tdata[REQ_ROW_LSB +: ROW_BITS];
   assign in_col   = req_tdata[REQ_COL_LSB +: COL_BITS];
   assign in_coeff = req_tdata[REQ_COEFF_LSB +: COEFF_IN_BITS];
   assign in_bit   = req_tdata[REQ_BIT_LSB];
   assign in_thr   = req_tdata[REQ_THR_LSB +: THR_BITS];

   assign in_row_ext   = CMP_BITS'(in_row);
   assign in_col_ext   = CMP_BITS'(in_col);
   assign in_row_var   = in_row_ext[VAR_BITS-1:0];
   assign in_col_var   = in_col_ext[VAR_BITS-1:0];
   assign in_row_valid = in_row_ext < max_ext;

   assign active_ext = CMP_BITS'(active_ff);
   assign max_ext    = CMP_BITS'(MAX_VARS);

   // Index of the last active variable: zero acts as one, oversize clamps.
   always_comb begin
      nm1_full = active_ext - CMP_BITS'(1);
      if (active_ff == '0) nm1_w = '0;
      else if (active_ext > max_ext) nm1_w = VAR_BITS'(MAX_VARS - 1);
      else nm1_w = nm1_full[VAR_BITS-1:0];
   end
   assign nm1_ext = CMP_BITS'(nm1_w);

   assign row_ext   = CMP_BITS'(row_ff);
   assign row_var   = row_ext[VAR_BITS-1:0];
   assign row_valid = row_ext < max_ext;

   assign status.in_mode    = req_tuser;
   assign status.in_flip_ok = in_row_ext <= nm1_ext;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         row_ff  <= in_row;
         thr_ff  <= in_thr;
      end
   end

   // Coupling store, written straight from the request transaction.
   assign coeff_we = cmd.capture && (req_tuser == MODE_LOAD_COEFF) &&
                     (in_row_ext <= in_col_ext) && (in_col_ext < max_ext);

   qmf_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_we),
      .wr_addr ({in_row_var, in_col_var}),
      .wr_data (in_coeff[CW-1:0]),
      .rd_en   (cmd.step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A flip scan walks one row of the symmetric view; an evaluation walks
   // the whole upper triangle, row by row.
   always_comb begin
      if (mode_ff == MODE_FLIP) begin
         rd_addr     = (row_var < j_ff) ? {row_var, j_ff} : {j_ff, row_var};
         include_now = (j_ff == row_var) || bits_ff[j_ff];
         status.scan_last = (j_ff == nm1_w);
      end else begin
         rd_addr     = {i_ff, j_ff};
         include_now = bits_ff[i_ff] && bits_ff[j_ff];
         status.scan_last = (i_ff == nm1_w) && (j_ff == nm1_w);
      end
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.capture) begin
         i_in = '0;
         j_in = '0;
      end else if (cmd.step) begin
         if (mode_ff == MODE_FLIP) begin
            j_in = j_ff + 1'b1;
         end else if (j_ff == nm1_w) begin
            i_in = i_ff + 1'b1;
            j_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      inc_ff <= include_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.step;
      end
   end

   assign coeff_ext = {{(ACC_BITS - CW){rd_data[CW-1]}}, rd_data};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (rd_valid_ff && inc_ff) begin
         acc_ff <= acc_ff + coeff_ext;
      end
   end

   // Result of the item.
   assign x_k         = row_valid && bits_ff[row_var];
   assign delta_full  = x_k ? -acc_ff : acc_ff;
   assign thr_ext     = $signed(ACC_BITS'(thr_ff));
   assign energy_ext  = {{(ACC_BITS - ENERGY_BITS){energy_ff[ENERGY_BITS-1]}}, energy_ff};
   assign energy_sum  = energy_ext + delta_full;
   assign flip_ok     = (mode_ff == MODE_FLIP) && (row_ext <= nm1_ext);
   assign flip_accept = flip_ok && (delta_full < thr_ext);

   always_comb begin
      bits_in = bits_ff;
      if (cmd.capture && (req_tuser == MODE_LOAD_BIT) && in_row_valid) begin
         bits_in[in_row_var] = in_bit;
      end
      if (cmd.finish && flip_accept) begin
         bits_in[row_var] = ~bits_ff[row_var];
      end
   end

   always_comb begin
      energy_in = energy_ff;
      if (cmd.finish) begin
         if (mode_ff == MODE_EVAL) energy_in = sat_energy(acc_ff);
         else if (flip_accept) energy_in = sat_energy(energy_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff   <= '0;
         energy_ff <= '0;
      end else begin
         bits_ff   <= bits_in;
         energy_ff <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_acc_ff    <= flip_accept;
         out_delta_ff  <= flip_ok ? sat_delta(delta_full) : '0;
         out_energy_ff <= energy_in;
         out_bit_ff    <= row_valid && (bits_ff[row_var] ^ flip_accept);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_USED_BITS){1'b0}},
                        out_bit_ff, out_energy_ff, out_delta_ff, out_acc_ff};

   `ASSERT_IMPLIES(a_scan_in_range, clock, reset, cmd.step, (j_ff <= nm1_w) && (i_ff <= j_ff))
   `ASSERT_NEXT(a_flip_toggles_bit, clock, reset, cmd.finish && flip_accept, bits_ff[row_var] != $past(bits_ff[row_var]))

endmodule
